// File: hdl/dvrt_pkg.sv
// ----------------------------------------------------------------------------
// dvrt_pkg : shared types and constants of the distance vector route table
// Entry layout, action and status codes, result bundle.
// ----------------------------------------------------------------------------
package dvrt_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 32;
  localparam int ID_W   = 8;
  localparam int COST_W = 8;
  localparam int IDX_W  = 5;

  localparam logic ACT_ADVERTISE = 1'b0;
  localparam logic ACT_DELETE    = 1'b1;

  typedef enum logic [2:0] {
    ST_ADDED    = 3'd0,
    ST_REPLACED = 3'd1,
    ST_IGNORED  = 3'd2,
    ST_FULL     = 3'd3,
    ST_DELETED  = 3'd4,
    ST_NOTFOUND = 3'd5
  } status_t;

  // one stored route
  typedef struct packed {
    logic [ID_W-1:0]   dest;
    logic [ID_W-1:0]   hop;
    logic [COST_W-1:0] cost;
  } entry_t;

  // one result item
  typedef struct packed {
    status_t           status;
    logic [IDX_W-1:0]  idx;
    logic [ID_W-1:0]   hop;
    logic [COST_W-1:0] cost;
  } res_t;

endpackage

// File: hdl/dvrt_ram.sv
// ----------------------------------------------------------------------------
// dvrt_ram : generic simple dual port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module dvrt_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/dvrt_ctrl.sv
// ----------------------------------------------------------------------------
// dvrt_ctrl : search and update sequencer
// Walks the table one slot a cycle, decides, writes back, hands the result on.
// ----------------------------------------------------------------------------
module dvrt_ctrl import dvrt_pkg::*; #(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  // item
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_action,
  input  logic [ID_W-1:0]   in_dest_id,
  input  logic [ID_W-1:0]   in_neighbor_id,
  input  logic [COST_W-1:0] in_advertised_distance,
  // result
  output logic              res_valid,
  input  logic              res_ready,
  output res_t              res,
  // RAM
  output logic              ram_we,
  output logic [AW-1:0]     ram_waddr,
  output entry_t            ram_wdata,
  output logic              ram_re,
  output logic [AW-1:0]     ram_raddr,
  input  entry_t            ram_rdata
);

  localparam int XW = (AW > IDX_W) ? AW : IDX_W;
  localparam logic [AW-1:0] LAST = AW'(TABLE_DEPTH - 1);

  typedef enum logic [1:0] {IDLE, SCAN, RESP} state_t;

  state_t             state_r, state_nxt;
  logic [TABLE_DEPTH-1:0] valid_r, valid_nxt;
  logic [AW-1:0]      rd_idx_r, rd_idx_nxt;
  logic               free_found_r, free_found_nxt;
  logic [AW-1:0]      free_idx_r, free_idx_nxt;
  logic               act_r;
  logic [ID_W-1:0]    dest_r, nbr_r;
  logic [COST_W-1:0]  adv_r;
  res_t               res_r, res_nxt;

  logic               hit, last, here_free;
  logic [COST_W:0]    sum;
  logic [COST_W-1:0]  new_cost;
  logic [AW-1:0]      slot;
  logic [XW-1:0]      slot_x;

  assign hit       = valid_r[rd_idx_r] && (ram_rdata.dest == dest_r);
  assign last      = (rd_idx_r == LAST);
  assign here_free = !valid_r[rd_idx_r];
  assign sum       = {1'b0, adv_r} + (COST_W+1)'(1);
  assign new_cost  = sum[COST_W] ? {COST_W{1'b1}} : sum[COST_W-1:0];

  always_comb begin
    state_nxt      = state_r;
    valid_nxt      = valid_r;
    rd_idx_nxt     = rd_idx_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    res_nxt        = res_r;
    ram_we         = 1'b0;
    ram_waddr      = rd_idx_r;
    ram_wdata      = '{dest: dest_r, hop: nbr_r, cost: new_cost};
    ram_re         = 1'b0;
    ram_raddr      = rd_idx_r + AW'(1);
    slot           = rd_idx_r;
    slot_x         = XW'(rd_idx_r);

    unique case (state_r)
      IDLE: begin
        ram_raddr = '0;
        if (in_valid) begin
          ram_re         = 1'b1;
          rd_idx_nxt     = '0;
          free_found_nxt = 1'b0;
          state_nxt      = SCAN;
        end
      end
      SCAN: begin
        if (hit) begin
          state_nxt = RESP;
          if (act_r == ACT_DELETE) begin
            valid_nxt[rd_idx_r] = 1'b0;
            res_nxt = '{status: ST_DELETED, idx: slot_x[IDX_W-1:0],
                        hop: ram_rdata.hop, cost: ram_rdata.cost};
          end else if ((sum < {1'b0, ram_rdata.cost}) || (nbr_r == ram_rdata.hop)) begin
            ram_we  = 1'b1;
            res_nxt = '{status: ST_REPLACED, idx: slot_x[IDX_W-1:0],
                        hop: nbr_r, cost: new_cost};
          end else begin
            res_nxt = '{status: ST_IGNORED, idx: slot_x[IDX_W-1:0],
                        hop: ram_rdata.hop, cost: ram_rdata.cost};
          end
        end else if (last) begin
          state_nxt = RESP;
          if (act_r == ACT_DELETE) begin
            res_nxt = '{status: ST_NOTFOUND, idx: '0, hop: '0, cost: '0};
          end else if (free_found_r || here_free) begin
            slot = free_found_r ? free_idx_r : rd_idx_r;
            slot_x           = XW'(slot);
            ram_waddr        = slot;
            ram_we           = 1'b1;
            valid_nxt[slot]  = 1'b1;
            res_nxt = '{status: ST_ADDED, idx: slot_x[IDX_W-1:0],
                        hop: nbr_r, cost: new_cost};
          end else begin
            res_nxt = '{status: ST_FULL, idx: '0, hop: '0, cost: '0};
          end
        end else begin
          ram_re     = 1'b1;
          rd_idx_nxt = rd_idx_r + AW'(1);
          if (here_free && !free_found_r) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = rd_idx_r;
          end
        end
      end
      RESP: begin
        if (res_ready) begin
          state_nxt = IDLE;
        end
      end
      default: state_nxt = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= IDLE;
      valid_r      <= '0;
      free_found_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      valid_r      <= valid_nxt;
      free_found_r <= free_found_nxt;
    end
    rd_idx_r   <= rd_idx_nxt;
    free_idx_r <= free_idx_nxt;
    res_r      <= res_nxt;
    if (in_valid && in_ready) begin
      act_r  <= in_action;
      dest_r <= in_dest_id;
      nbr_r  <= in_neighbor_id;
      adv_r  <= in_advertised_distance;
    end
  end

  assign in_ready  = (state_r == IDLE);
  assign res_valid = (state_r == RESP);
  assign res       = res_r;

  // scan pointer never leaves the table
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == SCAN) |-> (rd_idx_r <= LAST))
    else $error("scan index beyond table");

  // remembered free slot really is free while scanning
  a_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == SCAN && free_found_r) |-> !valid_r[free_idx_r])
    else $error("remembered free slot is occupied");

  // a waiting result holds until taken
  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res_ready) |=> (res_valid && $stable(res)))
    else $error("result changed while stalled");

  // an add or replace leaves the written slot valid
  a_wr_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> valid_nxt[ram_waddr])
    else $error("written slot not marked valid");

endmodule

// File: hdl/distance_vector_route_table_unit.sv
// ----------------------------------------------------------------------------
// distance_vector_route_table_unit : distance vector route table
// Route entries in RAM, valid bits in flops, linear search and write-back.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   in      | in_valid/in_ready, action, dest, nbr,   | input
//           | advertised distance                     |
//   out     | out_valid/out_ready, status, index,     | output
//           | next hop, distance                      |
//
// An item transfers in and starts the first read, then the search steps
// through the slots in turn via the single RAM read port, then the result
// passes to the output register. A hit ends the search early.
// Reset clears all valid bits at once.
// A result stalled at the output register holds the sequencer in its
// response state; the next item transfers once the result has moved on.
// ----------------------------------------------------------------------------
module distance_vector_route_table_unit import dvrt_pkg::*; #(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_action,
  input  logic [ID_W-1:0]   in_dest_id,
  input  logic [ID_W-1:0]   in_neighbor_id,
  input  logic [COST_W-1:0] in_advertised_distance,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        out_status,
  output logic [IDX_W-1:0]  out_entry_index,
  output logic [ID_W-1:0]   out_route_next_hop,
  output logic [COST_W-1:0] out_route_distance
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic          res_valid, res_ready;
  res_t          res;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  entry_t        ram_wdata, ram_rdata;
  logic          out_valid_r;
  res_t          out_r;

  dvrt_ctrl #(.TABLE_DEPTH(TABLE_DEPTH)) u_ctrl (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_action              (in_action),
    .in_dest_id             (in_dest_id),
    .in_neighbor_id         (in_neighbor_id),
    .in_advertised_distance (in_advertised_distance),
    .res_valid              (res_valid),
    .res_ready              (res_ready),
    .res                    (res),
    .ram_we                 (ram_we),
    .ram_waddr              (ram_waddr),
    .ram_wdata              (ram_wdata),
    .ram_re                 (ram_re),
    .ram_raddr              (ram_raddr),
    .ram_rdata              (ram_rdata)
  );

  // dest, hop and cost of every slot in one word
  dvrt_ram #(.WIDTH($bits(entry_t)), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // output register: loads whenever empty or being drained
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
    if (res_ready && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_r.status;
  assign out_entry_index    = out_r.idx;
  assign out_route_next_hop = out_r.hop;
  assign out_route_distance = out_r.cost;

endmodule
